// ----- sv/sobel_pkg.sv -----
// shared types and constants for the rgb sobel edge magnitude core
package sobel_pkg;

    localparam int CH_W    = 8;
    localparam int N_CH    = 3;
    localparam int PIX_W   = CH_W * N_CH;
    localparam int G_W     = 11;
    localparam int N_W     = 21;
    localparam int SAT_MAX = 255;

    localparam logic [N_W-1:0] ROOT_BIT0 = N_W'(1) << (N_W - 1);

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef logic [CH_W-1:0]         t_chan;
    typedef logic signed [G_W-1:0]   t_grad;
    typedef logic [N_W-1:0]          t_sq;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ----- sv/sobel_line_mem.sv -----
// two line stores: upper and middle rows, registered read
module sobel_line_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  sobel_pkg::t_mem_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_addr,
    input  sobel_pkg::t_pix             i_up_wdata,
    input  sobel_pkg::t_pix             i_mid_wdata,
    output sobel_pkg::t_pix             o_top,
    output sobel_pkg::t_pix             o_mid
);
    import sobel_pkg::*;

    t_pix r_upper  [DEPTH];
    t_pix r_middle [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_top <= r_upper[i_addr];
            o_mid <= r_middle[i_addr];
        end
        if (i_ctl.wr_en) begin
            r_upper[i_addr]  <= i_up_wdata;
            r_middle[i_addr] <= i_mid_wdata;
        end
    end

endmodule

// ----- sv/sobel_root.sv -----
// iterative integer square root for three channels with rounding and saturation
module sobel_root (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sobel_pkg::t_sq      i_n [sobel_pkg::N_CH],
    output logic                o_done,
    output sobel_pkg::t_chan    o_mag [sobel_pkg::N_CH]
);
    import sobel_pkg::*;

    logic r_busy;
    t_sq  r_bit;
    t_sq  r_rem [N_CH];
    t_sq  r_res [N_CH];
    t_sq  n_rem [N_CH];
    t_sq  n_res [N_CH];
    t_sq  trial [N_CH];
    t_sq  rnd   [N_CH];

    assign o_done = r_busy && (r_bit == '0);

    always_comb begin
        for (int k = 0; k < N_CH; k++) begin
            trial[k] = r_res[k] + r_bit;
            if (r_rem[k] >= trial[k]) begin
                n_rem[k] = r_rem[k] - trial[k];
                n_res[k] = (r_res[k] >> 1) + r_bit;
            end else begin
                n_rem[k] = r_rem[k];
                n_res[k] = r_res[k] >> 1;
            end
            rnd[k] = r_res[k] + ((r_rem[k] > r_res[k]) ? N_W'(1) : N_W'(0));
            o_mag[k] = (rnd[k] > N_W'(SAT_MAX)) ? CH_W'(SAT_MAX) : rnd[k][CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit <= ROOT_BIT0;
            for (int k = 0; k < N_CH; k++) begin
                r_rem[k] <= i_n[k];
                r_res[k] <= '0;
            end
        end else if (r_busy && r_bit != '0) begin
            r_bit <= r_bit >> 2;
            for (int k = 0; k < N_CH; k++) begin
                r_rem[k] <= n_rem[k];
                r_res[k] <= n_res[k];
            end
        end
    end

endmodule

// ----- sv/sobel_edge_magnitude_rgb_core.sv -----
// top level: rgb 3x3 sobel edge magnitude over a raster pixel stream
// a pixel transaction that yields a result shows it on m_axis, and the core takes
// the next transaction only once the previous one is done (tready only in idle)
// the 11-step shared square-root unit sets the pace; items without result skip it
// line stores read then write back one entry per item
// synchronous active-low reset clears counters and control state, sets config to 640x480
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // in_blue, in_green, in_red
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // edge_blue, edge_green, edge_red
    output logic        m_axis_tlast   // frame_last
);
    import sobel_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 3);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_GXY  = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]     r_state;
    logic [10:0]    r_frame_width;
    logic [15:0]    r_frame_height;
    logic [CW-1:0]  r_col;
    logic [HW-1:0]  r_row;

    logic [CW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [CW-1:0]  c0, c1, cc;
    logic [HW-1:0]  r0, r1;
    logic signed [HW:0] cr, h_s;
    logic           cur_valid;

    logic [AW-1:0]  r_addr;
    t_pix           r_pix;
    logic           r_valid, r_last;
    logic           r_top_ok, r_bot_ok, r_left_ok, r_right_ok;
    t_pix           r_win [3][3];
    t_grad          r_gx [N_CH];
    t_grad          r_gy [N_CH];
    t_chan          r_mag [N_CH];
    logic           r_ovalid;
    logic           r_olast;
    t_pix           r_odata;

    t_mem_ctl       mem_ctl;
    t_pix           mem_top, mem_mid;
    t_chan          mval [3][3];
    t_grad          gx [N_CH];
    t_grad          gy [N_CH];
    logic signed [2*G_W-1:0] sqx [N_CH];
    logic signed [2*G_W-1:0] sqy [N_CH];
    t_sq            sq_n [N_CH];
    logic           root_done;
    t_chan          root_mag [N_CH];
    logic           accept, out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // effective frame size and position of the incoming item
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
        h_s = $signed({1'b0, h_eff});

        if (r_col >= w_eff) begin
            c0 = '0;
            r0 = r_row + HW'(1);
        end else begin
            c0 = r_col;
            r0 = r_row;
        end
        if (r0 > h_eff + HW'(1) || (r0 == h_eff + HW'(1) && c0 != '0)) begin
            c0 = '0;
            r0 = '0;
        end

        if (c0 != '0) begin
            cr = $signed({1'b0, r0}) - (HW+1)'(1);
            cc = c0 - CW'(1);
        end else begin
            cr = $signed({1'b0, r0}) - (HW+1)'(2);
            cc = w_eff - CW'(1);
        end
        cur_valid = !cr[HW] && (cr < h_s);

        if (r0 == h_eff + HW'(1)) begin
            c1 = '0;
            r1 = '0;
        end else begin
            c1 = c0 + CW'(1);
            r1 = r0;
            if (c1 >= w_eff) begin
                c1 = '0;
                r1 = r0 + HW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 16'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_col   <= c1;
                        r_row   <= r1;
                        r_state <= S_RD;
                    end
                end
                S_RD:   r_state <= S_WB;
                S_WB:   r_state <= r_valid ? S_GXY : S_IDLE;
                S_GXY:  r_state <= S_SQ;
                S_SQ:   r_state <= S_ROOT;
                S_ROOT: begin
                    if (root_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= c0[AW-1:0];
            r_pix      <= s_axis_tdata;
            r_valid    <= cur_valid;
            r_last     <= (cr == h_s - (HW+1)'(1)) && (cc == w_eff - CW'(1));
            r_top_ok   <= (cr >= (HW+1)'(1));
            r_bot_ok   <= (cr < h_s - (HW+1)'(1));
            r_left_ok  <= (cc != '0);
            r_right_ok <= (cc < w_eff - CW'(1));
        end
        if (r_state == S_WB) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= mem_top;
            r_win[1][2] <= mem_mid;
            r_win[2][2] <= r_pix;
        end
        if (r_state == S_GXY) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (root_done) begin
            r_mag <= root_mag;
        end
        if (out_load) begin
            r_odata <= {r_mag[2], r_mag[1], r_mag[0]};
            r_olast <= r_last;
        end
    end

    assign mem_ctl.rd_en = (r_state == S_RD);
    assign mem_ctl.wr_en = (r_state == S_WB);

    sobel_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_addr      (r_addr),
        .i_up_wdata  (mem_mid),
        .i_mid_wdata (r_pix),
        .o_top       (mem_top),
        .o_mid       (mem_mid)
    );

    // masked window, gradients and squared sums
    always_comb begin
        for (int k = 0; k < N_CH; k++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if ((i == 0 && !r_top_ok) || (i == 2 && !r_bot_ok) ||
                        (j == 0 && !r_left_ok) || (j == 2 && !r_right_ok)) begin
                        mval[i][j] = '0;
                    end else begin
                        mval[i][j] = r_win[i][j][k*CH_W +: CH_W];
                    end
                end
            end
            gx[k] = $signed({3'b0, mval[0][2]}) + $signed({2'b0, mval[1][2], 1'b0})
                  + $signed({3'b0, mval[2][2]}) - $signed({3'b0, mval[0][0]})
                  - $signed({2'b0, mval[1][0], 1'b0}) - $signed({3'b0, mval[2][0]});
            gy[k] = $signed({3'b0, mval[2][0]}) + $signed({2'b0, mval[2][1], 1'b0})
                  + $signed({3'b0, mval[2][2]}) - $signed({3'b0, mval[0][0]})
                  - $signed({2'b0, mval[0][1], 1'b0}) - $signed({3'b0, mval[0][2]});
            sqx[k]  = r_gx[k] * r_gx[k];
            sqy[k]  = r_gy[k] * r_gy[k];
            sq_n[k] = sqx[k][N_W-1:0] + sqy[k][N_W-1:0];
        end
    end

    sobel_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQ),
        .i_n     (sq_n),
        .o_done  (root_done),
        .o_mag   (root_mag)
    );

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD))
        else $error("accepted transaction did not start a line store read");

    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == S_ROOT))
        else $error("root unit finished outside its state");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("result not presented after load");

    a_no_result_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && !r_valid) |=> s_axis_tready)
        else $error("item without result did not return to idle");

endmodule
